// ===== rtl/dcfi_pkg.sv =====
// ----------------------------------------------------------------------------
// dcfi_pkg
// Shared types and codes for the call-frame instruction encoder.
// ----------------------------------------------------------------------------
package dcfi_pkg;

    localparam int MAX_BYTES  = 16;
    localparam int BUF_W      = MAX_BYTES * 8;
    localparam int CNT_W      = $clog2(MAX_BYTES + 1);

    typedef enum logic [2:0] {
        ERR_NONE           = 3'd0,
        ERR_REGISTER       = 3'd1,
        ERR_CFA_NEGATIVE   = 3'd2,
        ERR_SAVE_OFFSET    = 3'd3,
        ERR_RESTORE_OFFSET = 3'd4,
        ERR_ORDER          = 3'd5
    } err_t;

    typedef enum logic [1:0] {
        MODE_DEF_CFA = 2'd0,
        MODE_SAVE    = 2'd1,
        MODE_RESTORE = 2'd2,
        MODE_UNUSED  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        CLASS_SP      = 2'd0,
        CLASS_INTEGER = 2'd1,
        CLASS_VECTOR  = 2'd2,
        CLASS_UNKNOWN = 2'd3
    } class_t;

    // encoded result of one action, handed to the output serialiser
    typedef struct packed {
        logic [BUF_W-1:0] bytes;
        logic [CNT_W-1:0] count;
        err_t             err;
    } enc_t;

endpackage

// ===== rtl/dcfi_encode.sv =====
// ----------------------------------------------------------------------------
// dcfi_encode
// Checks one action and builds its advance and instruction byte string.
// ----------------------------------------------------------------------------
module dcfi_encode
    import dcfi_pkg::*;
(
    input  logic [1:0]  mode,
    input  logic [31:0] code_offset,
    input  logic [1:0]  reg_class,
    input  logic [4:0]  reg_number,
    input  logic [63:0] frame_offset,
    input  logic [31:0] prev_offset,
    input  logic [31:0] code_size,
    output enc_t        enc
);

    localparam logic [7:0] OP_DEF_CFA       = 8'h0C;
    localparam logic [7:0] OP_OFFSET        = 8'h80;
    localparam logic [7:0] OP_RESTORE       = 8'hC0;
    localparam logic [7:0] OP_OFFSET_EXT    = 8'h05;
    localparam logic [7:0] OP_RESTORE_EXT   = 8'h06;
    localparam logic [7:0] OP_ADVANCE_SHORT = 8'h40;
    localparam logic [7:0] OP_ADVANCE1      = 8'h02;
    localparam logic [7:0] OP_ADVANCE2      = 8'h03;
    localparam logic [7:0] OP_ADVANCE4      = 8'h04;
    localparam logic [6:0] SP_REGNO         = 7'd31;
    localparam logic [6:0] VECTOR_BASE      = 7'd64;

    // unsigned LEB128 of a 63-bit value: nine groups of seven bits
    function automatic logic [71:0] uleb_bytes(input logic [62:0] v);
        logic [71:0] b;
        b = '0;
        for (int i = 0; i < 8; i++) begin
            b[i*8 +: 8] = {(v >> (7 * (i + 1))) != 63'd0, v[i*7 +: 7]};
        end
        b[71:64] = {1'b0, v[62:56]};
        return b;
    endfunction

    function automatic logic [3:0] uleb_len(input logic [62:0] v);
        logic [3:0] n;
        n = 4'd1;
        for (int i = 0; i < 8; i++) begin
            if ((v >> (7 * (i + 1))) != 63'd0) begin
                n = n + 4'd1;
            end
        end
        return n;
    endfunction

    logic        neg;
    logic [31:0] delta;
    logic [6:0]  regno;
    logic        reg_ok;
    logic        ext_reg;
    logic [63:0] neg_offset;
    err_t        err;
    logic [39:0] adv_bytes;
    logic [2:0]  adv_len;
    logic [15:0] op_bytes;
    logic [1:0]  op_len;
    logic [62:0] uleb_val;
    logic        uleb_use;
    logic [71:0] ul_bytes;
    logic [3:0]  ul_len;
    logic [87:0] tail;
    logic [BUF_W-1:0] all_bytes;

    assign neg        = frame_offset[63];
    assign delta      = code_offset - prev_offset;
    assign neg_offset = 64'd0 - frame_offset;
    assign ext_reg    = regno[6];

    always_comb
    begin
        regno  = SP_REGNO;
        reg_ok = 1'b1;
        unique case (reg_class)
            CLASS_SP:      regno = SP_REGNO;
            CLASS_INTEGER:
            begin
                regno  = {2'b00, reg_number};
                reg_ok = (reg_number != 5'd31);
            end
            CLASS_VECTOR:  regno = VECTOR_BASE | {2'b00, reg_number};
            default:       reg_ok = 1'b0;
        endcase
    end

    always_comb
    begin
        err = ERR_NONE;
        if (code_offset < prev_offset || code_offset > code_size
            || code_offset[1:0] != 2'b00) begin
            err = ERR_ORDER;
        end else if (!reg_ok) begin
            err = ERR_REGISTER;
        end else if (mode == MODE_DEF_CFA && neg) begin
            err = ERR_CFA_NEGATIVE;
        end else if (mode == MODE_SAVE && (!neg || frame_offset == {1'b1, 63'd0}
                     || frame_offset[2:0] != 3'd0)) begin
            err = ERR_SAVE_OFFSET;
        end else if (mode == MODE_RESTORE && frame_offset != 64'd0) begin
            err = ERR_RESTORE_OFFSET;
        end
    end

    always_comb
    begin
        adv_bytes = '0;
        adv_len   = 3'd0;
        if (delta == 32'd0) begin
            adv_len = 3'd0;
        end else if (delta <= 32'h3F) begin
            adv_bytes[7:0] = OP_ADVANCE_SHORT | {2'b00, delta[5:0]};
            adv_len        = 3'd1;
        end else if (delta <= 32'hFF) begin
            adv_bytes[15:0] = {delta[7:0], OP_ADVANCE1};
            adv_len         = 3'd2;
        end else if (delta <= 32'hFFFF) begin
            adv_bytes[23:0] = {delta[15:0], OP_ADVANCE2};
            adv_len         = 3'd3;
        end else begin
            adv_bytes = {delta, OP_ADVANCE4};
            adv_len   = 3'd5;
        end
    end

    always_comb
    begin
        op_bytes = '0;
        op_len   = 2'd0;
        uleb_val = '0;
        uleb_use = 1'b0;
        unique case (mode)
            MODE_DEF_CFA:
            begin
                op_bytes = {1'b0, regno, OP_DEF_CFA};
                op_len   = 2'd2;
                uleb_val = frame_offset[62:0];
                uleb_use = 1'b1;
            end
            MODE_SAVE:
            begin
                if (ext_reg) begin
                    op_bytes = {1'b0, regno, OP_OFFSET_EXT};
                    op_len   = 2'd2;
                end else begin
                    op_bytes = {8'h00, OP_OFFSET | {1'b0, regno}};
                    op_len   = 2'd1;
                end
                uleb_val = {2'b00, neg_offset[63:3]};
                uleb_use = 1'b1;
            end
            MODE_RESTORE:
            begin
                if (ext_reg) begin
                    op_bytes = {1'b0, regno, OP_RESTORE_EXT};
                    op_len   = 2'd2;
                end else begin
                    op_bytes = {8'h00, OP_RESTORE | {1'b0, regno}};
                    op_len   = 2'd1;
                end
            end
            default:
            begin
                op_len = 2'd0;
            end
        endcase
    end

    assign ul_bytes  = uleb_use ? uleb_bytes(uleb_val) : 72'd0;
    assign ul_len    = uleb_use ? uleb_len(uleb_val) : 4'd0;
    assign tail      = {72'd0, op_bytes} | ({16'd0, ul_bytes} << {op_len, 3'b000});
    assign all_bytes = {88'd0, adv_bytes} | ({40'd0, tail} << {adv_len, 3'b000});

    always_comb
    begin
        enc.err = err;
        if (err != ERR_NONE) begin
            enc.bytes = '0;
            enc.count = CNT_W'(1);
        end else begin
            enc.bytes = all_bytes;
            enc.count = CNT_W'(adv_len) + CNT_W'(op_len) + CNT_W'(ul_len);
        end
    end

endmodule

// ===== rtl/dcfi_serializer.sv =====
// ----------------------------------------------------------------------------
// dcfi_serializer
// Holds one encoded action and sends its bytes one per transaction.
// ----------------------------------------------------------------------------
module dcfi_serializer
    import dcfi_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       load,
    input  enc_t       enc,
    output logic       can_load,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       last,
    output logic [2:0] error_code
);

    logic [BUF_W-1:0] buf_reg;
    logic [BUF_W-1:0] buf_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    err_t             err_reg;
    err_t             err_next;
    logic             xfer;

    assign out_valid  = (cnt_reg != '0);
    assign xfer       = out_valid && !out_stall;
    assign can_load   = (cnt_reg == '0) || (cnt_reg == CNT_W'(1) && !out_stall);
    assign out_byte   = buf_reg[7:0];
    assign last       = (cnt_reg == CNT_W'(1));
    assign error_code = err_reg;

    always_comb
    begin
        buf_next = buf_reg;
        cnt_next = cnt_reg;
        err_next = err_reg;
        if (load) begin
            buf_next = enc.bytes;
            cnt_next = enc.count;
            err_next = enc.err;
        end else if (xfer) begin
            buf_next = buf_reg >> 8;
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg <= buf_next;
        err_reg <= err_next;
    end

endmodule

// ===== rtl/dwarf_cfi_action_encoder.sv =====
// ----------------------------------------------------------------------------
// dwarf_cfi_action_encoder
// Encodes unwind actions into DWARF advance and call-frame instruction bytes.
// ----------------------------------------------------------------------------
// Path: an action is held in the input register, then loaded into the output
//   buffer, which offers its first byte; out_stall can hold it at either step.
// Throughput: one byte per cycle while out_stall is low; an action sends N
//   bytes, N being its byte count (0 to 16, one for an error).
// The single-entry output buffer sets the rate; the input register refills
//   in the cycle the buffer sends its last byte.
// Reset: buffer and input register empty, previous offset 0, code size 4.
// ----------------------------------------------------------------------------
module dwarf_cfi_action_encoder
    import dcfi_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  mode,
    input  logic [31:0] code_offset,
    input  logic [1:0]  reg_class,
    input  logic [4:0]  reg_number,
    input  logic [63:0] frame_offset,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_byte,
    output logic        last,
    output logic [2:0]  error_code
);

    logic        s1_valid_reg;
    logic        s1_valid_next;
    logic [1:0]  s1_mode_reg;
    logic [31:0] s1_offset_reg;
    logic [1:0]  s1_class_reg;
    logic [4:0]  s1_number_reg;
    logic [63:0] s1_frame_reg;
    logic [31:0] prev_offset_reg;
    logic [31:0] prev_offset_next;
    logic [31:0] code_size_reg;
    logic [31:0] code_size_next;
    logic        accept;
    logic        take;
    logic        can_load;
    enc_t        enc;

    assign cfg_ready = 1'b1;
    assign take      = s1_valid_reg && can_load;
    assign in_stall  = s1_valid_reg && !can_load;
    assign accept    = in_valid && !in_stall;

    dcfi_encode u_encode (
        .mode         (s1_mode_reg),
        .code_offset  (s1_offset_reg),
        .reg_class    (s1_class_reg),
        .reg_number   (s1_number_reg),
        .frame_offset (s1_frame_reg),
        .prev_offset  (prev_offset_reg),
        .code_size    (code_size_reg),
        .enc          (enc)
    );

    dcfi_serializer u_serializer (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (take),
        .enc        (enc),
        .can_load   (can_load),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_byte   (out_byte),
        .last       (last),
        .error_code (error_code)
    );

    always_comb
    begin
        s1_valid_next    = accept || (s1_valid_reg && !take);
        prev_offset_next = (take && enc.err == ERR_NONE) ? s1_offset_reg : prev_offset_reg;
        code_size_next   = (cfg_valid && cfg_ready) ? cfg_data : code_size_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg    <= 1'b0;
            prev_offset_reg <= 32'd0;
            code_size_reg   <= 32'd4;
        end else begin
            s1_valid_reg    <= s1_valid_next;
            prev_offset_reg <= prev_offset_next;
            code_size_reg   <= code_size_next;
        end
    end

    // hold the item while the buffer is busy
    always_ff @(posedge clk)
    begin
        if (accept) begin
            s1_mode_reg   <= mode;
            s1_offset_reg <= code_offset;
            s1_class_reg  <= reg_class;
            s1_number_reg <= reg_number;
            s1_frame_reg  <= frame_offset;
        end
    end

    a_error_single: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error_code != ERR_NONE |-> last && out_byte == 8'd0)
        else $error("error transaction is not a single zero byte");

    a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg && out_valid)
        else $error("input stalled with an empty output buffer");

    a_prev_on_take: assert property (@(posedge clk) disable iff (!rst_n)
        !take |=> prev_offset_reg == $past(prev_offset_reg))
        else $error("previous offset changed without an encoded action");

endmodule
